@@ rtl/core/ilffa_pkg.sv @@
// Package with the shared types and constants of the first-fit heap allocator.
`default_nettype none
package ilffa_pkg;
   localparam int HeapLimit = 65536;
   localparam int TagWords  = HeapLimit / 8;
   localparam int TagAw     = $clog2(TagWords);
   localparam int TagW      = 13;
   localparam logic [16:0] ChunkReset = 17'd4096;

   localparam logic [1:0] StatusDone = 2'd0;
   localparam logic [1:0] StatusNull = 2'd1;
   localparam logic [1:0] StatusOom  = 2'd2;

   localparam logic ReqAlloc = 1'b0;
   localparam logic ReqFree  = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_INIT0, ST_INIT1, ST_INIT2, ST_INIT3,
      ST_GROW0, ST_GROW1, ST_GROW2,
      ST_MRG_RD0, ST_MRG_RD1, ST_MRG_RD2, ST_MRG_DEC, ST_MRG_WR1,
      ST_DISPATCH,
      ST_FIT_RD, ST_FIT_WAIT, ST_FIT_CHK,
      ST_EXT,
      ST_PLC_W0, ST_PLC_W1, ST_PLC_W2, ST_PLC_W3,
      ST_CHK_RD, ST_CHK_WAIT, ST_CHK_CHK,
      ST_FREE_W0, ST_FREE_W1,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      AFTER_REQ, AFTER_PLACE, AFTER_RESP
   } cont_type;
endpackage
`default_nettype wire

@@ rtl/core/implicit_list_first_fit_allocator_top.sv @@
// Top level of the boundary-tag first-fit heap allocator.
//
// Channel   Ports                                Direction
// request   req_valid/req_ready, req_*            in
// response  rsp_valid/rsp_ready, rsp_*            out
// config    csr_wr_en, csr_wr_data                in
//
// One request at a time. A sequencer drives one tag memory port: each block
// visited in a walk takes a read, a wait and a check state. Growing the heap
// adds states to a request, and the request that starts the heap also writes
// the pad word, prologue and epilogue first. Reset clears the break, the start
// flag, the response valid flag and the sequencer, and loads the chunk size
// with its default; the memory needs no clearing pass.
// The response waits in a register until taken, and the next request is
// accepted once it has gone.
`default_nettype none
module implicit_list_first_fit_allocator_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [15:0] req_size,
   input  wire logic [15:0] req_block_addr,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [15:0] rsp_result_addr,
   output logic      [1:0]  rsp_status,
   input  wire logic        csr_wr_en,
   input  wire logic [16:0] csr_wr_data
);
   localparam int Aw = ilffa_pkg::TagAw;

   ilffa_pkg::state_type state_ff, state_in;
   ilffa_pkg::cont_type  cont_ff, cont_in;

   logic [16:0] chunk_ff;
   logic [16:0] brk_ff, brk_in;
   logic        started_ff, started_in;
   logic        type_ff, type_in;
   logic [15:0] size_ff, size_in;
   logic [15:0] addr_ff, addr_in;
   logic [16:0] asize_ff, asize_in;
   logic [16:0] bp_ff, bp_in;       // current block payload pointer
   logic [16:0] sz_ff, sz_in;       // general size register
   logic [16:0] psz_ff, psz_in;
   logic        pa_ff, pa_in;
   logic [16:0] nsz_ff, nsz_in;
   logic        na_ff, na_in;
   logic [15:0] res_ff, res_in;
   logic [1:0]  stat_ff, stat_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_addr_ff, rsp_addr_in;
   logic [1:0]  rsp_stat_ff, rsp_stat_in;

   // Memory port signals.
   logic                         mem_we;
   logic [16:0]                  mem_byte;
   logic [ilffa_pkg::TagW-1:0]   mem_wd, mem_rd;
   logic [16:0]                  rd_size;
   logic                         rd_alloc;
   logic                         mem_ok;

   assign rd_size  = {1'b0, mem_rd[12:1], 4'b0000};
   assign rd_alloc = mem_rd[0];
   // Tag words hold size bits 15:4 as bits 12:1 (sizes below 65536), bit 0 allocated.
   // Written addresses past the memory are dropped.
   assign mem_ok = (mem_byte[16:3] < 14'(ilffa_pkg::TagWords));

   ilffa_ram #(.Width(ilffa_pkg::TagW), .Depth(ilffa_pkg::TagWords)) u_tags (
      .clock  (clock),
      .wr_en  (mem_we & mem_ok),
      .addr   (mem_byte[Aw+2:3]),
      .wr_data(mem_wd),
      .rd_data(mem_rd)
   );

   // Pack a size and an allocated bit into a tag word.
   function automatic logic [12:0] tag(input logic [16:0] s, input logic a);
      tag = {s[15:4], a};
   endfunction

   assign req_ready       = (state_ff == ilffa_pkg::ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_addr = rsp_addr_ff;
   assign rsp_status      = rsp_stat_ff;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff <= ilffa_pkg::ChunkReset;
      end else if (csr_wr_en) begin
         chunk_ff <= csr_wr_data;
      end
   end

   // State and data registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ilffa_pkg::ST_IDLE;
         brk_ff       <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         brk_ff       <= brk_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cont_ff     <= cont_in;
      type_ff     <= type_in;
      size_ff     <= size_in;
      addr_ff     <= addr_in;
      asize_ff    <= asize_in;
      bp_ff       <= bp_in;
      sz_ff       <= sz_in;
      psz_ff      <= psz_in;
      pa_ff       <= pa_in;
      nsz_ff      <= nsz_in;
      na_ff       <= na_in;
      res_ff      <= res_in;
      stat_ff     <= stat_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   // Sequencer.
   always_comb begin
      logic [16:0] words_b;
      logic [17:0] gsum;
      logic [16:0] msz;
      logic [16:0] rem;
      state_in     = state_ff;
      cont_in      = cont_ff;
      brk_in       = brk_ff;
      started_in   = started_ff;
      type_in      = type_ff;
      size_in      = size_ff;
      addr_in      = addr_ff;
      asize_in     = asize_ff;
      bp_in        = bp_ff;
      sz_in        = sz_ff;
      psz_in       = psz_ff;
      pa_in        = pa_ff;
      nsz_in       = nsz_ff;
      na_in        = na_ff;
      res_in       = res_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_stat_in  = rsp_stat_ff;
      mem_we       = 1'b0;
      mem_byte     = '0;
      mem_wd       = '0;
      words_b      = '0;
      gsum         = '0;
      msz          = '0;
      rem          = sz_ff - asize_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ilffa_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               type_in = req_type;
               size_in = req_size;
               addr_in = req_block_addr;
               res_in  = '0;
               stat_in = ilffa_pkg::StatusDone;
               if (req_type == ilffa_pkg::ReqFree && req_block_addr == '0) begin
                  stat_in  = ilffa_pkg::StatusNull;
                  state_in = ilffa_pkg::ST_RESP;
               end else if (!started_ff) begin
                  state_in = ilffa_pkg::ST_INIT0;
               end else begin
                  state_in = ilffa_pkg::ST_DISPATCH;
               end
            end
         end
         // Pad word, prologue and epilogue.
         ilffa_pkg::ST_INIT0: begin
            mem_we = 1'b1; mem_byte = 17'd0; mem_wd = '0;
            state_in = ilffa_pkg::ST_INIT1;
         end
         ilffa_pkg::ST_INIT1: begin
            mem_we = 1'b1; mem_byte = 17'd8; mem_wd = tag(17'd16, 1'b1);
            state_in = ilffa_pkg::ST_INIT2;
         end
         ilffa_pkg::ST_INIT2: begin
            mem_we = 1'b1; mem_byte = 17'd16; mem_wd = tag(17'd16, 1'b1);
            state_in = ilffa_pkg::ST_INIT3;
         end
         ilffa_pkg::ST_INIT3: begin
            mem_we = 1'b1; mem_byte = 17'd24; mem_wd = tag(17'd0, 1'b1);
            brk_in = 17'd32;
            started_in = 1'b1;
            sz_in = chunk_ff;
            cont_in = ilffa_pkg::AFTER_REQ;
            state_in = ilffa_pkg::ST_GROW0;
         end
         // Grow: sz_ff holds the requested bytes on entry.
         ilffa_pkg::ST_GROW0: begin
            words_b = {sz_ff[16:3], 3'b000};
            if (sz_ff[3]) begin
               words_b = words_b + 17'd8;
            end
            if (words_b == '0) begin
               words_b = 17'd16;
            end
            gsum = {1'b0, brk_ff} + {1'b0, words_b};
            if (sz_ff[16] && sz_ff[3]) begin
               gsum = 18'h3ffff;
            end
            if (gsum > 18'(ilffa_pkg::HeapLimit)) begin
               bp_in = '0;
               if (cont_ff == ilffa_pkg::AFTER_PLACE) begin
                  stat_in = ilffa_pkg::StatusOom;
                  state_in = ilffa_pkg::ST_RESP;
               end else begin
                  state_in = ilffa_pkg::ST_DISPATCH;
               end
            end else begin
               sz_in = words_b;
               bp_in = brk_ff;
               mem_we = 1'b1; mem_byte = brk_ff - 17'd8; mem_wd = tag(words_b, 1'b0);
               state_in = ilffa_pkg::ST_GROW1;
            end
         end
         ilffa_pkg::ST_GROW1: begin
            mem_we = 1'b1; mem_byte = bp_ff + sz_ff - 17'd16; mem_wd = tag(sz_ff, 1'b0);
            state_in = ilffa_pkg::ST_GROW2;
         end
         ilffa_pkg::ST_GROW2: begin
            mem_we = 1'b1; mem_byte = bp_ff + sz_ff - 17'd8; mem_wd = tag(17'd0, 1'b1);
            brk_in = brk_ff + sz_ff;
            state_in = ilffa_pkg::ST_MRG_RD0;
         end
         // Merge: bp_ff is a free block of size sz_ff. Read data arrives in the state after its address.
         ilffa_pkg::ST_MRG_RD0: begin
            mem_byte = bp_ff - 17'd16;
            state_in = ilffa_pkg::ST_MRG_RD1;
         end
         ilffa_pkg::ST_MRG_RD1: begin
            mem_byte = bp_ff + sz_ff - 17'd8;
            psz_in = rd_size; pa_in = rd_alloc;
            state_in = ilffa_pkg::ST_MRG_RD2;
         end
         ilffa_pkg::ST_MRG_RD2: begin
            nsz_in = rd_size; na_in = rd_alloc;
            state_in = ilffa_pkg::ST_MRG_DEC;
         end
         ilffa_pkg::ST_MRG_DEC: begin
            msz = sz_ff;
            if (!na_ff) begin
               msz = msz + nsz_ff;
            end
            if (!pa_ff) begin
               msz = msz + psz_ff;
               bp_in = bp_ff - psz_ff;
            end
            sz_in = msz;
            if (pa_ff && na_ff) begin
               state_in = (cont_ff == ilffa_pkg::AFTER_RESP) ? ilffa_pkg::ST_RESP
                                                             : ilffa_pkg::ST_DISPATCH;
               if (cont_ff == ilffa_pkg::AFTER_PLACE) begin
                  state_in = ilffa_pkg::ST_PLC_W0;
               end
            end else begin
               mem_we = 1'b1;
               mem_byte = (pa_ff ? bp_ff : bp_ff - psz_ff) - 17'd8;
               mem_wd = tag(msz, 1'b0);
               state_in = ilffa_pkg::ST_MRG_WR1;
            end
         end
         ilffa_pkg::ST_MRG_WR1: begin
            mem_we = 1'b1; mem_byte = bp_ff + sz_ff - 17'd16; mem_wd = tag(sz_ff, 1'b0);
            state_in = (cont_ff == ilffa_pkg::AFTER_RESP) ? ilffa_pkg::ST_RESP
                                                          : ilffa_pkg::ST_DISPATCH;
            if (cont_ff == ilffa_pkg::AFTER_PLACE) begin
               state_in = ilffa_pkg::ST_PLC_W0;
            end
         end
         // Start the request proper once the heap is up.
         ilffa_pkg::ST_DISPATCH: begin
            if (type_ff == ilffa_pkg::ReqAlloc) begin
               if (size_ff == '0) begin
                  stat_in = ilffa_pkg::StatusNull;
                  state_in = ilffa_pkg::ST_RESP;
               end else begin
                  if (size_ff <= 16'd16) begin
                     asize_in = 17'd32;
                  end else begin
                     asize_in = ({1'b0, size_ff} + 17'd31) & 17'h1fff0;
                  end
                  bp_in = 17'd16;
                  state_in = ilffa_pkg::ST_FIT_RD;
               end
            end else begin
               bp_in = 17'd16;
               state_in = ilffa_pkg::ST_CHK_RD;
            end
         end
         // First-fit walk.
         ilffa_pkg::ST_FIT_RD: begin
            mem_byte = bp_ff - 17'd8;
            state_in = ilffa_pkg::ST_FIT_WAIT;
         end
         ilffa_pkg::ST_FIT_WAIT: begin
            mem_byte = bp_ff - 17'd8;
            state_in = ilffa_pkg::ST_FIT_CHK;
         end
         ilffa_pkg::ST_FIT_CHK: begin
            if (rd_size == '0 || bp_ff[16]) begin
               state_in = ilffa_pkg::ST_EXT;
            end else if (!rd_alloc && asize_ff <= rd_size) begin
               sz_in = rd_size;
               state_in = ilffa_pkg::ST_PLC_W0;
            end else begin
               bp_in = bp_ff + rd_size;
               state_in = ilffa_pkg::ST_FIT_RD;
            end
         end
         ilffa_pkg::ST_EXT: begin
            sz_in = (asize_ff > chunk_ff) ? asize_ff : chunk_ff;
            cont_in = ilffa_pkg::AFTER_PLACE;
            state_in = ilffa_pkg::ST_GROW0;
         end
         // Place: sz_ff holds the block size.
         ilffa_pkg::ST_PLC_W0: begin
            mem_we = 1'b1; mem_byte = bp_ff - 17'd8;
            res_in = bp_ff[15:0];
            mem_wd = (rem >= 17'd32) ? tag(asize_ff, 1'b1) : tag(sz_ff, 1'b1);
            state_in = ilffa_pkg::ST_PLC_W1;
         end
         ilffa_pkg::ST_PLC_W1: begin
            mem_we = 1'b1;
            if (rem >= 17'd32) begin
               mem_byte = bp_ff + asize_ff - 17'd16; mem_wd = tag(asize_ff, 1'b1);
               state_in = ilffa_pkg::ST_PLC_W2;
            end else begin
               mem_byte = bp_ff + sz_ff - 17'd16; mem_wd = tag(sz_ff, 1'b1);
               state_in = ilffa_pkg::ST_RESP;
            end
         end
         ilffa_pkg::ST_PLC_W2: begin
            mem_we = 1'b1; mem_byte = bp_ff + asize_ff - 17'd8; mem_wd = tag(rem, 1'b0);
            state_in = ilffa_pkg::ST_PLC_W3;
         end
         ilffa_pkg::ST_PLC_W3: begin
            mem_we = 1'b1; mem_byte = bp_ff + sz_ff - 17'd16; mem_wd = tag(rem, 1'b0);
            state_in = ilffa_pkg::ST_RESP;
         end
         // Walk to check that the freed address heads an allocated block.
         ilffa_pkg::ST_CHK_RD: begin
            mem_byte = bp_ff - 17'd8;
            state_in = ilffa_pkg::ST_CHK_WAIT;
         end
         ilffa_pkg::ST_CHK_WAIT: begin
            mem_byte = bp_ff - 17'd8;
            state_in = ilffa_pkg::ST_CHK_CHK;
         end
         ilffa_pkg::ST_CHK_CHK: begin
            if (rd_size == '0 || bp_ff > {1'b0, addr_ff}) begin
               stat_in = ilffa_pkg::StatusNull;
               state_in = ilffa_pkg::ST_RESP;
            end else if (bp_ff == {1'b0, addr_ff}) begin
               if (rd_alloc && bp_ff != 17'd16) begin
                  sz_in = rd_size;
                  state_in = ilffa_pkg::ST_FREE_W0;
               end else begin
                  stat_in = ilffa_pkg::StatusNull;
                  state_in = ilffa_pkg::ST_RESP;
               end
            end else begin
               bp_in = bp_ff + rd_size;
               state_in = ilffa_pkg::ST_CHK_RD;
            end
         end
         ilffa_pkg::ST_FREE_W0: begin
            mem_we = 1'b1; mem_byte = bp_ff - 17'd8; mem_wd = tag(sz_ff, 1'b0);
            state_in = ilffa_pkg::ST_FREE_W1;
         end
         ilffa_pkg::ST_FREE_W1: begin
            mem_we = 1'b1; mem_byte = bp_ff + sz_ff - 17'd16; mem_wd = tag(sz_ff, 1'b0);
            cont_in = ilffa_pkg::AFTER_RESP;
            state_in = ilffa_pkg::ST_MRG_RD0;
         end
         // Hand the result to the output register.
         ilffa_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = res_ff;
               rsp_stat_in  = stat_ff;
               state_in     = ilffa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ilffa_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   // A request is only taken with the sequencer idle and no beat waiting, and it moves the sequencer out of idle.
   a_req_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ilffa_pkg::ST_IDLE))
      else $error("request accepted but sequencer stayed idle");
   // The break never passes the heap limit.
   a_brk_limit: assert property (@(posedge clock) disable iff (reset)
      brk_ff <= 17'(ilffa_pkg::HeapLimit))
      else $error("heap break beyond limit");
   // An allocated address is always 16-byte aligned.
   a_res_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_addr_ff[3:0] == 4'd0))
      else $error("unaligned result address");
`endif
endmodule
`default_nettype wire

@@ rtl/core/ilffa_ram.sv @@
// Generic single-port RAM with registered read data.
`default_nettype none
module ilffa_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // The write, when enabled, and the read share one address; a read in a write's cycle returns the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire
